// ----- hdl/lps_pkg.sv -----
// Shared constants, types and helpers for the lexicographic point sorter.
`default_nettype none

package lps_pkg;

    localparam int POINTS      = 64;
    localparam int IDX_W       = $clog2(POINTS);
    localparam int CNT_W       = $clog2(POINTS + 1);
    localparam int COORD_W     = 32;
    localparam int INDEX_OUT_W = 6;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [IDX_W-1:0]   idx_t;
    typedef logic [CNT_W-1:0]   cnt_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t z;
    } point_t;

    // Sort key: sign-flipped coordinates so an unsigned compare orders them as
    // signed, then the load index to break ties and keep load order.
    typedef struct packed {
        coord_t kx;
        coord_t ky;
        coord_t kz;
        idx_t   idx;
    } key_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN,
        ST_EMIT
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic start_scan;
        logic scan_step;
        logic emit_done;
        logic clear_count;
    } cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic issue_last;
        logic out_last;
    } status_t;

    // Toggle the sign bit: maps two's complement order onto unsigned order.
    function automatic coord_t flip_sign(input coord_t v);
        return v ^ {1'b1, {(COORD_W-1){1'b0}}};
    endfunction

endpackage

`default_nettype wire

// ----- hdl/lps_if.sv -----
// Valid/ready channel interfaces for point input and sorted output.
`default_nettype none

interface lps_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [lps_pkg::COORD_W-1:0] px;
    logic signed [lps_pkg::COORD_W-1:0] py;
    logic signed [lps_pkg::COORD_W-1:0] pz;
    logic                               last_point;

    modport source (output valid, px, py, pz, last_point, input ready);
    modport sink   (input valid, px, py, pz, last_point, output ready);
endinterface

interface lps_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [lps_pkg::COORD_W-1:0]     sx;
    logic signed [lps_pkg::COORD_W-1:0]     sy;
    logic signed [lps_pkg::COORD_W-1:0]     sz;
    logic        [lps_pkg::INDEX_OUT_W-1:0] source_index;
    logic                                   last_sorted;

    modport source (output valid, sx, sy, sz, source_index, last_sorted, input ready);
    modport sink   (input valid, sx, sy, sz, source_index, last_sorted, output ready);
endinterface

`default_nettype wire

// ----- hdl/lps_ctrl.sv -----
// Controller state machine: load, scan for next key, drain, emit.
`default_nettype none

module lps_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    input  wire logic             in_last,
    input  wire logic             out_ready,
    input  wire lps_pkg::status_t status,
    output lps_pkg::cmd_t         cmd,
    output logic                  in_ready,
    output logic                  out_valid
);

    lps_pkg::state_t state_reg;
    lps_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lps_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            lps_pkg::ST_LOAD:
            begin
                if (in_valid && in_last)
                begin
                    state_next = lps_pkg::ST_SCAN;
                end
            end
            lps_pkg::ST_SCAN:
            begin
                if (status.issue_last)
                begin
                    state_next = lps_pkg::ST_DRAIN;
                end
            end
            lps_pkg::ST_DRAIN:
            begin
                state_next = lps_pkg::ST_EMIT;
            end
            lps_pkg::ST_EMIT:
            begin
                if (out_ready)
                begin
                    state_next = status.out_last ? lps_pkg::ST_LOAD : lps_pkg::ST_SCAN;
                end
            end
            default:
            begin
                state_next = lps_pkg::ST_LOAD;
            end
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        cmd       = '0;
        in_ready  = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            lps_pkg::ST_LOAD:
            begin
                in_ready       = 1'b1;
                cmd.load       = in_valid;
                cmd.start_scan = in_valid && in_last;
            end
            lps_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            lps_pkg::ST_DRAIN:
            begin
                cmd = '0;
            end
            lps_pkg::ST_EMIT:
            begin
                out_valid       = 1'b1;
                cmd.emit_done   = out_ready;
                cmd.clear_count = out_ready && status.out_last;
                cmd.start_scan  = out_ready && !status.out_last;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/lps_datapath.sv -----
// Datapath: point store, scan pipeline and running-minimum key that drives the outputs.
`default_nettype none

module lps_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lps_pkg::cmd_t                     cmd,
    input  wire lps_pkg::point_t                   in_point,
    output lps_pkg::status_t                       status,
    output lps_pkg::point_t                        out_point,
    output logic [lps_pkg::INDEX_OUT_W-1:0]        out_index,
    output logic                                   out_last
);

    lps_pkg::point_t mem [lps_pkg::POINTS];

    lps_pkg::cnt_t   count_reg;
    lps_pkg::idx_t   rd_idx_reg;
    logic            rd_vld_reg;
    lps_pkg::point_t rd_data_reg;
    lps_pkg::idx_t   rd_tag_reg;
    lps_pkg::key_t   best_reg;
    logic            best_vld_reg;
    lps_pkg::key_t   prev_reg;
    logic            have_prev_reg;
    lps_pkg::idx_t   k_reg;

    lps_pkg::idx_t   last_idx;
    logic            wr_en;
    lps_pkg::key_t   cand;
    logic            take;

    assign last_idx = lps_pkg::IDX_W'(count_reg - lps_pkg::CNT_W'(1));
    assign wr_en    = cmd.load && (count_reg < lps_pkg::CNT_W'(lps_pkg::POINTS));

    // Candidate key from the registered read data
    always_comb
    begin
        cand.kx  = lps_pkg::flip_sign(rd_data_reg.x);
        cand.ky  = lps_pkg::flip_sign(rd_data_reg.y);
        cand.kz  = lps_pkg::flip_sign(rd_data_reg.z);
        cand.idx = rd_tag_reg;
        take     = rd_vld_reg
                   && (!have_prev_reg || (cand > prev_reg))
                   && (!best_vld_reg || (cand < best_reg));
    end

    // Point store: one write port while loading, one registered read while scanning
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[lps_pkg::IDX_W-1:0]] <= in_point;
        end
        if (cmd.scan_step)
        begin
            rd_data_reg <= mem[rd_idx_reg];
            rd_tag_reg  <= rd_idx_reg;
        end
        if (take)
        begin
            best_reg <= cand;
        end
        if (cmd.emit_done)
        begin
            prev_reg <= best_reg;
        end
    end

    // Control counters and flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            rd_idx_reg    <= '0;
            rd_vld_reg    <= 1'b0;
            best_vld_reg  <= 1'b0;
            have_prev_reg <= 1'b0;
            k_reg         <= '0;
        end
        else
        begin
            rd_vld_reg <= cmd.scan_step;

            if (cmd.clear_count)
            begin
                count_reg <= '0;
            end
            else if (wr_en)
            begin
                count_reg <= count_reg + lps_pkg::CNT_W'(1);
            end

            if (cmd.start_scan)
            begin
                rd_idx_reg <= '0;
            end
            else if (cmd.scan_step)
            begin
                rd_idx_reg <= rd_idx_reg + lps_pkg::IDX_W'(1);
            end

            if (cmd.start_scan)
            begin
                best_vld_reg <= 1'b0;
            end
            else if (take)
            begin
                best_vld_reg <= 1'b1;
            end

            // Finished run: forget the previous key and restart the rank
            if (cmd.clear_count)
            begin
                have_prev_reg <= 1'b0;
                k_reg         <= '0;
            end
            else if (cmd.emit_done)
            begin
                have_prev_reg <= 1'b1;
                k_reg         <= k_reg + lps_pkg::IDX_W'(1);
            end
        end
    end

    assign status.issue_last = (rd_idx_reg == last_idx);
    assign status.out_last   = (k_reg == last_idx);

    // Result fields from the winning key
    assign out_point.x = lps_pkg::flip_sign(best_reg.kx);
    assign out_point.y = lps_pkg::flip_sign(best_reg.ky);
    assign out_point.z = lps_pkg::flip_sign(best_reg.kz);
    assign out_index   = lps_pkg::INDEX_OUT_W'(best_reg.idx);
    assign out_last    = status.out_last;

endmodule

`default_nettype wire

// ----- hdl/lexicographic_point_sort_top.sv -----
// Load rate: one point transaction per cycle until the point marked last.
// Sort: each result needs a scan of all n stored points through the single
// read port, a drain state, then an emit state that holds until the output
// is taken.
// Reset clears the point count and the controller; store contents stay
// undefined and are only read after being written in the current set.
`default_nettype none

module lexicographic_point_sort_top (
    input  wire logic clk,
    input  wire logic rst_n,
    lps_in_if.sink    in_ch,
    lps_out_if.source out_ch
);

    lps_pkg::cmd_t    cmd;
    lps_pkg::status_t status;
    lps_pkg::point_t  in_point;
    lps_pkg::point_t  out_point;

    assign in_point.x = in_ch.px;
    assign in_point.y = in_ch.py;
    assign in_point.z = in_ch.pz;

    lps_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_last   (in_ch.last_point),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid)
    );

    lps_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_point  (in_point),
        .status    (status),
        .out_point (out_point),
        .out_index (out_ch.source_index),
        .out_last  (out_ch.last_sorted)
    );

    assign out_ch.sx = out_point.x;
    assign out_ch.sy = out_point.y;
    assign out_ch.sz = out_point.z;

`ifndef SYNTHESIS
    // Loading and emitting never overlap
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input and output active together");

    // Final sorted transaction returns the block to loading
    a_back_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.last_sorted) |=> in_ch.ready)
        else $error("not loading after last sorted transaction");

    // Closing point stops loading until the run is out
    a_stop_load: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.last_point) |=> !in_ch.ready)
        else $error("still loading after last point");
`endif

endmodule

`default_nettype wire
